// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define CCAL_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define CCAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ccal_pkg.sv -----
// types, constants and helper functions for the clock-calendar block
`default_nettype none

package ccal_pkg;

  localparam logic [5:0] SEC_MAX      = 6'd59;
  localparam logic [5:0] MIN_MAX      = 6'd59;
  localparam logic [4:0] HOUR_MAX     = 5'd23;
  localparam logic [4:0] HALF_DAY     = 5'd12;
  localparam logic [3:0] MONTH_MAX    = 4'd12;
  localparam logic [5:0] RING_SECONDS = 6'd21;

  localparam int CFG_DATA_W = 6;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_LOAD    = 2'd1,
    OP_SILENCE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_HOUR_MODE    = 2'd0,
    CFG_ALARM_HOUR   = 2'd1,
    CFG_ALARM_MINUTE = 2'd2,
    CFG_ALARM_ENABLE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic       hour_mode_24;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
    logic       alarm_enable;
  } cfg_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [4:0] day_of_month;
    logic [3:0] month_number;
    logic       silenced;
    logic       flash_phase;
  } clk_state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
    logic [4:0] load_day;
    logic [3:0] load_month;
  } item_t;

  typedef struct packed {
    logic [4:0] shown_hour;
    logic [5:0] minute_now;
    logic [5:0] second_now;
    logic [4:0] day_now;
    logic [3:0] month_now;
    logic       pm_flag;
    logic       alarm_ringing;
    logic       display_invert;
  } result_t;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  function automatic logic [4:0] days_in(input logic [3:0] month);
    logic [4:0] len;
    if (month < 4'd1 || month > MONTH_MAX) begin
      len = 5'd31;
    end else begin
      len = MONTH_LEN[month - 4'd1];
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ccal_cfg.sv -----
// configuration register bank
`default_nettype none

module ccal_cfg
  import ccal_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hour_mode_24 <= 1'b0;
      cfg.alarm_hour   <= 5'd23;
      cfg.alarm_minute <= 6'd0;
      cfg.alarm_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_HOUR_MODE:    cfg.hour_mode_24 <= cfg_data[0];
        CFG_ALARM_HOUR:   cfg.alarm_hour   <= cfg_data[4:0];
        CFG_ALARM_MINUTE: cfg.alarm_minute <= cfg_data[5:0];
        CFG_ALARM_ENABLE: cfg.alarm_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ccal_next.sv -----
// next-state and result logic for one item
`default_nettype none

module ccal_next
  import ccal_pkg::*;
(
  input  clk_state_t cur,
  input  cfg_t       cfg,
  input  item_t      item,
  output clk_state_t nxt,
  output result_t    res
);

  logic       match_cur;
  logic       match_nxt;
  logic [4:0] ld_hour;
  logic [5:0] ld_min;
  logic [5:0] ld_sec;
  logic [3:0] ld_month;
  logic [4:0] ld_len;
  logic [4:0] ld_day;
  logic [4:0] half_hour;

  assign match_cur = cfg.alarm_enable && (cur.hours == cfg.alarm_hour)
                     && (cur.minutes == cfg.alarm_minute);

  // load clamping
  always_comb begin
    ld_hour  = (item.load_hour > HOUR_MAX) ? HOUR_MAX : item.load_hour;
    ld_min   = (item.load_minute > MIN_MAX) ? MIN_MAX : item.load_minute;
    ld_sec   = (item.load_second > SEC_MAX) ? SEC_MAX : item.load_second;
    if (item.load_month < 4'd1) begin
      ld_month = 4'd1;
    end else if (item.load_month > MONTH_MAX) begin
      ld_month = MONTH_MAX;
    end else begin
      ld_month = item.load_month;
    end
    ld_len = days_in(ld_month);
    if (item.load_day < 5'd1) begin
      ld_day = 5'd1;
    end else if (item.load_day > ld_len) begin
      ld_day = ld_len;
    end else begin
      ld_day = item.load_day;
    end
  end

  always_comb begin
    nxt = cur;
    unique case (op_t'(item.operation))
      OP_TICK: begin
        if (match_cur) begin
          if (cur.seconds < RING_SECONDS && !cur.silenced) begin
            nxt.flash_phase = ~cur.flash_phase;
          end else begin
            nxt.flash_phase = 1'b0;
          end
        end else begin
          nxt.silenced    = 1'b0;
          nxt.flash_phase = 1'b0;
        end
        if (cur.seconds >= SEC_MAX) begin
          nxt.seconds = 6'd0;
          if (cur.minutes >= MIN_MAX) begin
            nxt.minutes = 6'd0;
            if (cur.hours >= HOUR_MAX) begin
              nxt.hours = 5'd0;
              if (cur.day_of_month >= days_in(cur.month_number)) begin
                nxt.day_of_month = 5'd1;
                nxt.month_number = (cur.month_number >= MONTH_MAX) ? 4'd1
                                   : cur.month_number + 4'd1;
              end else begin
                nxt.day_of_month = cur.day_of_month + 5'd1;
              end
            end else begin
              nxt.hours = cur.hours + 5'd1;
            end
          end else begin
            nxt.minutes = cur.minutes + 6'd1;
          end
        end else begin
          nxt.seconds = cur.seconds + 6'd1;
        end
      end
      OP_LOAD: begin
        nxt.hours        = ld_hour;
        nxt.minutes      = ld_min;
        nxt.seconds      = ld_sec;
        nxt.day_of_month = ld_day;
        nxt.month_number = ld_month;
      end
      OP_SILENCE: begin
        nxt.silenced    = 1'b1;
        nxt.flash_phase = 1'b0;
      end
      default: ;
    endcase
  end

  assign match_nxt = cfg.alarm_enable && (nxt.hours == cfg.alarm_hour)
                     && (nxt.minutes == cfg.alarm_minute);

  always_comb begin
    half_hour = (nxt.hours >= HALF_DAY) ? nxt.hours - HALF_DAY : nxt.hours;
    if (cfg.hour_mode_24) begin
      res.shown_hour = nxt.hours;
    end else begin
      res.shown_hour = (half_hour == 5'd0) ? HALF_DAY : half_hour;
    end
    res.minute_now     = nxt.minutes;
    res.second_now     = nxt.seconds;
    res.day_now        = nxt.day_of_month;
    res.month_now      = nxt.month_number;
    res.pm_flag        = (nxt.hours >= HALF_DAY);
    res.alarm_ringing  = match_nxt && (nxt.seconds < RING_SECONDS) && !nxt.silenced;
    res.display_invert = nxt.flash_phase;
  end

endmodule

`default_nettype wire

// ----- rtl/calendar_clock_with_alarm_core.sv -----
// top level of the clock-calendar with alarm
//
// input stream: each beat is one item; s_tuser carries the operation
// (tick, load time and date, silence alarm), s_tdata the load values.
// output stream: one beat per input beat, the time, date and alarm
// flags after that item, in the same order as the items.
// configuration: cfg_valid/cfg_index/cfg_data write one register per
// beat; cfg_ready is always high. write only while no item is in flight.
// path: an accepted item waits in the input register; when it advances, its
// result loads the result register, from which the result beat is sent.
// throughput: one item per cycle while the output does not stall; the clock
// state update is the single stage that sets that figure.
// reset: the clock starts at 10:59:56 on day 8 of month 8, alarm off,
// 12-hour display; both pipeline registers empty.
// stall: while m_tready is low the result register holds its beat and the
// input register fills; s_tready then drops until the output drains.
`default_nettype none

`include "assert_macros.svh"

module calendar_clock_with_alarm_core
  import ccal_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // hour[4:0] minute[10:5] second[16:11] day[21:17] month[25:22] zero[31:26]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // operation[1:0]
  input  wire logic [1:0]            s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // shown_hour[4:0] minute[10:5] second[16:11] day[21:17] month[25:22]
  // pm[26] ringing[27] invert[28] zero[31:29]
  output logic [OUT_DATA_W-1:0]      m_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  item_t      in_item;
  logic       in_valid;
  logic       advance;
  clk_state_t state;
  clk_state_t state_next;
  result_t    res_next;
  result_t    res;
  logic       time_ok;
  logic       date_ok;
  logic       silence_in;
  logic       silence_ok;

  ccal_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.operation   <= s_tuser;
      in_item.load_hour   <= s_tdata[4:0];
      in_item.load_minute <= s_tdata[10:5];
      in_item.load_second <= s_tdata[16:11];
      in_item.load_day    <= s_tdata[21:17];
      in_item.load_month  <= s_tdata[25:22];
    end
  end

  ccal_next u_next (
    .cur  (state),
    .cfg  (cfg),
    .item (in_item),
    .nxt  (state_next),
    .res  (res_next)
  );

  // clock state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.hours        <= 5'd10;
      state.minutes      <= 6'd59;
      state.seconds      <= 6'd56;
      state.day_of_month <= 5'd8;
      state.month_number <= 4'd8;
      state.silenced     <= 1'b0;
      state.flash_phase  <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = {3'd0, res.display_invert, res.alarm_ringing, res.pm_flag,
                    res.month_now, res.day_now, res.second_now, res.minute_now,
                    res.shown_hour};

  assign time_ok = (state.seconds <= SEC_MAX) && (state.minutes <= MIN_MAX)
                   && (state.hours <= HOUR_MAX);
  assign date_ok = (state.month_number >= 4'd1) && (state.month_number <= MONTH_MAX)
                   && (state.day_of_month >= 5'd1)
                   && (state.day_of_month <= days_in(state.month_number));
  assign silence_in = advance && (in_item.operation == OP_SILENCE);
  assign silence_ok = state.silenced && !state.flash_phase;

  `CCAL_ASSERT_ALWAYS(a_time_range, time_ok, "time out of range")
  `CCAL_ASSERT_ALWAYS(a_date_range, date_ok, "date out of range")
  `CCAL_ASSERT_NEXT(a_result_follows, advance, m_tvalid, "result beat lost")
  `CCAL_ASSERT_NEXT(a_silence_clears_flash, silence_in, silence_ok, "silence not applied")

endmodule

`default_nettype wire
